### hdl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle during reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, idle during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hdl/jkse_pkg.sv
// ---------------------------------------------------------------------------
// jkse_pkg
// Types and constants of the JSON key string extractor.
// ---------------------------------------------------------------------------
package jkse_pkg;

  localparam int MAX_KEY_BYTES = 16;
  localparam int WIN_BYTES     = MAX_KEY_BYTES + 3;

  // Configuration register indexes
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LEN  = 2'd2;
  localparam logic [1:0] REG_CAPACITY = 2'd3;

  // Scanner modes
  localparam logic [1:0] MODE_SEARCH = 2'd0;
  localparam logic [1:0] MODE_SKIP   = 2'd1;
  localparam logic [1:0] MODE_STR    = 2'd2;
  localparam logic [1:0] MODE_ESC    = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_FIN  = 2'd2;

  // Character constants
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic [7:0] doc_byte;
    logic       doc_last;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  value_char;
    logic [15:0] value_number;
    logic [15:0] found_total;
    logic        run_end;
  } out_t;

  // All results caused by one input byte
  typedef struct packed {
    logic        has_char;
    logic        has_end;
    logic        has_fin;
    logic [7:0]  ch;
    logic [15:0] found;
  } bundle_t;

endpackage

### hdl/jkse_cell.sv
// ---------------------------------------------------------------------------
// jkse_cell
// One byte of the search window: shifts toward its neighbor and compares the
// byte it is about to take against its pattern byte.
// ---------------------------------------------------------------------------
module jkse_cell
  import jkse_pkg::*;
(
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] byte_in,
  input  logic [7:0] want,
  input  logic       care,
  output logic [7:0] byte_out,
  output logic       hit
);

  logic [7:0] window_byte;

  // window byte, no reset: the fill counter decides what is valid
  always_ff @(posedge clk) begin
    if (shift) begin
      window_byte <= byte_in;
    end
  end

  assign byte_out = window_byte;
  assign hit      = !care || (byte_in == want);

endmodule

### hdl/jkse_queue.sv
// ---------------------------------------------------------------------------
// jkse_queue
// Two-entry queue of result bundles, unpacked into single result transfers.
// ---------------------------------------------------------------------------
module jkse_queue
  import jkse_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output out_t    out_data
);

  bundle_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;

  bundle_t    head;
  logic       xfer;
  logic       last_one;
  logic [1:0] kind;

  assign head      = entries[rd_ptr];
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign xfer      = out_valid && !out_stall;
  assign last_one  = ($countones({head.has_char, head.has_end, head.has_fin}) == 1);

  // pick the earliest pending result of the head bundle
  always_comb begin
    if (head.has_char) begin
      kind = KIND_CHAR;
    end else if (head.has_end) begin
      kind = KIND_END;
    end else begin
      kind = KIND_FIN;
    end
  end

  always_comb begin
    out_data.result_kind = kind;
    out_data.value_char  = (kind == KIND_CHAR) ? head.ch : 8'd0;
    if (kind == KIND_FIN || head.found == 16'd0) begin
      out_data.value_number = 16'd0;
    end else begin
      out_data.value_number = head.found - 16'd1;
    end
    out_data.found_total = head.found;
    out_data.run_end     = last_one;
  end

  assign count_next = count + {1'b0, push} - {1'b0, xfer && last_one};

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (xfer && last_one) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count_next;
    end
  end

  // entry storage; a push never lands on a head that is being drained
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
    if (xfer && !last_one) begin
      if (head.has_char) begin
        entries[rd_ptr].has_char <= 1'b0;
      end else begin
        entries[rd_ptr].has_end <= 1'b0;
      end
    end
  end

endmodule

### hdl/json_key_string_extractor_top.sv
// ---------------------------------------------------------------------------
// json_key_string_extractor_top
// Streams the string values that follow a configured key in a JSON document.
// ---------------------------------------------------------------------------
// Usage:
//   in_data carries one document byte per transfer (in_valid / in_stall);
//   doc_last marks the final byte. out_data carries one result per transfer
//   (out_valid / out_stall): a value character, an end of value, or the
//   document-finished record with the found count.
//   Configuration (key bytes, key length, output capacity) is written on the
//   cfg port while no document is in flight; cfg_ready is always high.
// Timing:
//   A byte is taken every cycle while in_stall is low. Its results are
//   registered in the result queue and leave at one per cycle while
//   out_stall is low. The search is a 19-cell shift chain whose cells
//   each compare one window byte, so a match is decided in the cycle
//   the byte arrives.
//   A two-bundle result queue sits between the sides; in_stall rises only
//   while both bundles are pending, which a receiver stall can cause.
// Reset:
//   rst (synchronous) empties the queue, restores the register defaults and
//   puts the scanner in search mode. The last byte of a document returns the
//   scanner, counters and window to that state too.
// ---------------------------------------------------------------------------
module json_key_string_extractor_top
  import jkse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // configuration registers
  logic [63:0] key_bytes_low;
  logic [63:0] key_bytes_high;
  logic [4:0]  key_length;
  logic [15:0] output_capacity;

  // scanner state
  logic [1:0]  mode;
  logic [1:0]  mode_next;
  logic [4:0]  fill;
  logic [4:0]  fill_next;
  logic [15:0] found;
  logic [15:0] found_next;
  logic [15:0] emitted;
  logic [15:0] emitted_next;

  logic          accept;
  logic          full;
  logic          shift;
  logic          match;
  logic [4:0]    fill_inc;
  logic [5:0]    pat_len;
  logic          key_ok;
  logic          emit_ok;
  logic          want_char;
  bundle_t       bundle;
  logic [127:0]  key_vec;
  logic [7:0]    win    [WIN_BYTES];
  logic [7:0]    feed   [WIN_BYTES];
  logic [7:0]    want   [WIN_BYTES];
  logic          care   [WIN_BYTES];
  logic [WIN_BYTES-1:0] hits;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !full;
  assign in_stall  = full;
  assign key_vec   = {key_bytes_high, key_bytes_low};
  assign key_ok    = (key_length <= 5'(MAX_KEY_BYTES));
  assign pat_len   = {1'b0, key_length} + 6'd3;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes_low   <= 64'd0;
      key_bytes_high  <= 64'd0;
      key_length      <= 5'd0;
      output_capacity <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEY_LOW:  key_bytes_low   <= cfg_data;
        REG_KEY_HIGH: key_bytes_high  <= cfg_data;
        REG_KEY_LEN:  key_length      <= cfg_data[4:0];
        REG_CAPACITY: output_capacity <= cfg_data[15:0];
        default:      key_length      <= key_length;
      endcase
    end
  end

  // window chain: pattern is right-aligned, ending in quote and colon
  for (genvar j = 0; j < WIN_BYTES; j++) begin : g_cell
    if (j == WIN_BYTES - 1) begin : g_colon
      assign want[j] = CH_COLON;
      assign care[j] = 1'b1;
      assign feed[j] = in_data.doc_byte;
    end else if (j == WIN_BYTES - 2) begin : g_quote
      assign want[j] = CH_QUOTE;
      assign care[j] = 1'b1;
      assign feed[j] = win[j+1];
    end else begin : g_key
      localparam logic [5:0] POS = 6'(j);
      logic [5:0] sum;
      logic [5:0] kidx;

      assign sum  = POS + {1'b0, key_length};
      assign kidx = sum - 6'(WIN_BYTES - 2);

      assign care[j] = (sum >= 6'(MAX_KEY_BYTES));
      assign want[j] = (sum == 6'(MAX_KEY_BYTES)) ? CH_QUOTE
                     : key_vec[{kidx[3:0], 3'b000} +: 8];
      assign feed[j] = win[j+1];
    end

    jkse_cell u_cell (
      .clk      (clk),
      .shift    (shift),
      .byte_in  (feed[j]),
      .want     (want[j]),
      .care     (care[j]),
      .byte_out (win[j]),
      .hit      (hits[j])
    );
  end

  assign fill_inc = (fill < 5'(WIN_BYTES)) ? fill + 5'd1 : fill;
  assign match    = key_ok && ({1'b0, fill_inc} >= pat_len) && (&hits);
  assign emit_ok  = ({1'b0, emitted} + 17'd1) < {1'b0, output_capacity};

  // per-byte scanner step
  always_comb begin
    mode_next       = mode;
    fill_next       = fill;
    found_next      = found;
    emitted_next    = emitted;
    shift           = 1'b0;
    want_char       = 1'b0;
    bundle.has_char = 1'b0;
    bundle.has_end  = 1'b0;
    bundle.has_fin  = 1'b0;
    bundle.ch       = in_data.doc_byte;

    unique case (mode)
      MODE_SEARCH: begin
        shift     = accept;
        fill_next = fill_inc;
        if (match) begin
          mode_next = MODE_SKIP;
          fill_next = 5'd0;
        end
      end
      MODE_SKIP: begin
        if (in_data.doc_byte == CH_SPACE) begin
          mode_next = MODE_SKIP;
        end else if (in_data.doc_byte == CH_QUOTE) begin
          if (found != 16'hFFFF) begin
            found_next = found + 16'd1;
          end
          mode_next = MODE_STR;
        end else begin
          mode_next = MODE_SEARCH;
          shift     = accept;
          fill_next = 5'd1;
        end
      end
      MODE_STR: begin
        if (in_data.doc_byte == CH_QUOTE) begin
          bundle.has_end = 1'b1;
          mode_next      = MODE_SEARCH;
          fill_next      = 5'd0;
        end else if (in_data.doc_byte == CH_BSL && !in_data.doc_last) begin
          mode_next = MODE_ESC;
        end else begin
          want_char = 1'b1;
        end
      end
      MODE_ESC: begin
        want_char = 1'b1;
        mode_next = MODE_STR;
        case (in_data.doc_byte)
          CH_N:    bundle.ch = CH_LF;
          CH_T:    bundle.ch = CH_TAB;
          CH_R:    bundle.ch = CH_CR;
          default: bundle.ch = in_data.doc_byte;
        endcase
      end
      default: mode_next = MODE_SEARCH;
    endcase

    // emit limit
    if (want_char && emit_ok) begin
      bundle.has_char = 1'b1;
      emitted_next    = emitted + 16'd1;
    end
    bundle.found = found_next;

    // end of document: close an open value, report, return to reset
    if (in_data.doc_last) begin
      if (mode_next == MODE_STR || mode_next == MODE_ESC) begin
        bundle.has_end = 1'b1;
      end
      bundle.has_fin = 1'b1;
      mode_next      = MODE_SEARCH;
      fill_next      = 5'd0;
      found_next     = 16'd0;
      emitted_next   = 16'd0;
    end
  end

  // scanner registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_SEARCH;
      fill    <= 5'd0;
      found   <= 16'd0;
      emitted <= 16'd0;
    end else if (accept) begin
      mode    <= mode_next;
      fill    <= fill_next;
      found   <= found_next;
      emitted <= emitted_next;
    end
  end

  jkse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && (bundle.has_char || bundle.has_end || bundle.has_fin)),
    .push_data (bundle),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### hdl/jkse_checker.sv
// ---------------------------------------------------------------------------
// jkse_checker
// Port-level checks of the extractor's result stream.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module jkse_checker
  import jkse_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))

  // the finished record closes the run of its byte
  `ASSERT_IMPLY(a_fin_run_end, clk, rst, out_valid && out_data.result_kind == KIND_FIN, out_data.run_end && out_data.value_number == 16'd0)

  // only value characters carry a character
  `ASSERT_IMPLY(a_char_zero, clk, rst, out_valid && out_data.result_kind != KIND_CHAR, out_data.value_char == 8'd0)

  // a character or end of value belongs to a counted value
  `ASSERT_IMPLY(a_value_counted, clk, rst, out_valid && out_data.result_kind != KIND_FIN, out_data.found_total != 16'd0 && out_data.value_number == out_data.found_total - 16'd1)

endmodule

bind json_key_string_extractor_top jkse_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/json_key_string_extractor_top_tb.sv
// ----------------------------------------------------------------------------
// json_key_string_extractor_top_tb
// Self-checking bench for the key string extractor. Documents are built from
// key/value pairs, near misses and noise. Each accepted byte runs through a
// local copy of the scanner, and the results it causes are queued and
// compared in order against the output stream. Several key and capacity
// settings are used, with random idling on both sides and one long receiver
// hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_key_string_extractor_top_tb;
  import jkse_pkg::*;

  // Scanner copy and queue of results still to arrive
  class extract_tracker;
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [4:0]  key_len;
    logic [15:0] capacity;
    logic [7:0]  recent_bytes [WIN_BYTES];
    int unsigned fill;
    int unsigned found;
    int unsigned emitted;
    logic [1:0]  mode;
    out_t        awaited_results [$];
    int          errors;

    function new();
      key_low  = '0;
      key_high = '0;
      key_len  = '0;
      capacity = 16'hFFFF;
      errors   = 0;
      clear_doc();
    endfunction

    function void clear_doc();
      foreach (recent_bytes[i]) recent_bytes[i] = '0;
      fill    = 0;
      found   = 0;
      emitted = 0;
      mode    = MODE_SEARCH;
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] data);
      case (idx)
        REG_KEY_LOW:  key_low  = data;
        REG_KEY_HIGH: key_high = data;
        REG_KEY_LEN:  key_len  = data[4:0];
        REG_CAPACITY: capacity = data[15:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] key_byte(int i);
      if (i < 8) return key_low[8*i +: 8];
      if (i < 16) return key_high[8*(i-8) +: 8];
      return 8'h00;
    endfunction

    function void shift_in(logic [7:0] b);
      for (int i = 0; i < WIN_BYTES - 1; i++) recent_bytes[i] = recent_bytes[i+1];
      recent_bytes[WIN_BYTES-1] = b;
    endfunction

    // quote, key, quote, colon at the tail of the window
    function bit window_matches();
      int len;
      int base;
      logic [7:0] want;
      if (key_len > MAX_KEY_BYTES) return 1'b0;
      len = int'(key_len) + 3;
      if (fill < len) return 1'b0;
      base = WIN_BYTES - len;
      for (int i = 0; i < len; i++) begin
        if (i == 0 || i == len - 2) want = CH_QUOTE;
        else if (i == len - 1) want = CH_COLON;
        else want = key_byte(i - 1);
        if (recent_bytes[base + i] != want) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void add_result(logic [1:0] kind, logic [7:0] ch);
      out_t r;
      r.result_kind  = kind;
      r.value_char   = (kind == KIND_CHAR) ? ch : 8'h00;
      r.value_number = (kind == KIND_FIN || found == 0) ? 16'd0 : 16'(found - 1);
      r.found_total  = 16'(found);
      r.run_end      = 1'b0;
      awaited_results.push_back(r);
    endfunction

    function void add_char(logic [7:0] ch);
      if (emitted + 1 < capacity) begin
        emitted++;
        add_result(KIND_CHAR, ch);
      end
    endfunction

    // Advance the scanner by one accepted byte
    function void take_byte(in_t item);
      logic [7:0] b;
      bit         last;
      int         start;
      out_t       tail;
      b     = item.doc_byte;
      last  = item.doc_last;
      start = awaited_results.size();
      case (mode)
        MODE_SEARCH: begin
          shift_in(b);
          if (fill < WIN_BYTES) fill++;
          if (window_matches()) begin
            mode = MODE_SKIP;
            fill = 0;
          end
        end
        MODE_SKIP: begin
          if (b == CH_QUOTE) begin
            if (found < 65535) found++;
            mode = MODE_STR;
          end else if (b != CH_SPACE) begin
            // search restarts with this byte
            mode = MODE_SEARCH;
            shift_in(b);
            fill = 1;
          end
        end
        MODE_STR: begin
          if (b == CH_QUOTE) begin
            add_result(KIND_END, 8'h00);
            mode = MODE_SEARCH;
            fill = 0;
          end else if (b == CH_BSL && !last) begin
            mode = MODE_ESC;
          end else begin
            add_char(b);
          end
        end
        default: begin
          case (b)
            CH_N:    add_char(CH_LF);
            CH_T:    add_char(CH_TAB);
            CH_R:    add_char(CH_CR);
            default: add_char(b);
          endcase
          mode = MODE_STR;
        end
      endcase
      if (last) begin
        if (mode == MODE_STR || mode == MODE_ESC) add_result(KIND_END, 8'h00);
        add_result(KIND_FIN, 8'h00);
        clear_doc();
      end
      if (awaited_results.size() > start) begin
        tail = awaited_results.pop_back();
        tail.run_end = 1'b1;
        awaited_results.push_back(tail);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind=%0d char=%02h num=%0d found=%0d end=%0b",
                   got.result_kind, got.value_char, got.value_number,
                   got.found_total, got.run_end);
        return;
      end
      want = awaited_results.pop_front();
      if (got.result_kind !== want.result_kind || got.value_char !== want.value_char ||
          got.value_number !== want.value_number ||
          got.found_total !== want.found_total || got.run_end !== want.run_end) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected kind=%0d char=%02h num=%0d found=%0d end=%0b",
                   want.result_kind, want.value_char, want.value_number,
                   want.found_total, want.run_end);
          $display("          actual   kind=%0d char=%02h num=%0d found=%0d end=%0b",
                   got.result_kind, got.value_char, got.value_number,
                   got.found_total, got.run_end);
        end
      end
    endfunction

    function void check_drained();
      if (awaited_results.size() != 0) begin
        errors += awaited_results.size();
        $display("%0d expected results never arrived", awaited_results.size());
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_KEY_LOW;
  logic [63:0] cfg_data  = '0;

  extract_tracker tracker = new();

  int         send_idle_pct  = 26;
  int         recv_idle_pct  = 88;
  int         random_sent    = 0;
  bit         pressure_armed = 1'b0;
  bit         pressure_done  = 1'b0;
  logic [7:0] doc_q [$];
  logic [7:0] key_copy [16];
  int         key_use = 0;

  json_key_string_extractor_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Observe both channels; pre-edge values are sampled
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) tracker.take_byte(in_data);
      if (out_valid && !out_stall) tracker.check_result(out_data);
    end
  end

  // Receiver: random stall, plus one long hold-off once armed
  initial begin
    forever begin
      @(posedge clk);
      if (pressure_armed && !pressure_done && out_valid) begin
        out_stall     <= 1'b1;
        pressure_done = 1'b1;
        repeat (60) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // ---- document building ----

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) doc_q.push_back(s[i]);
  endfunction

  function automatic void add_key_pattern();
    doc_q.push_back(CH_QUOTE);
    for (int i = 0; i < key_use; i++) doc_q.push_back(key_copy[i]);
    doc_q.push_back(CH_QUOTE);
    doc_q.push_back(CH_COLON);
    repeat ($urandom_range(3)) doc_q.push_back(CH_SPACE);
  endfunction

  // String body without the closing quote
  function automatic void add_value_body(int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(7))
        0, 1, 2: doc_q.push_back(8'($urandom_range(97, 122)));
        3: begin
          do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSL);
          doc_q.push_back(b);
        end
        4: begin
          doc_q.push_back(CH_BSL);
          case ($urandom_range(2))
            0:       doc_q.push_back(CH_N);
            1:       doc_q.push_back(CH_T);
            default: doc_q.push_back(CH_R);
          endcase
        end
        5: begin
          doc_q.push_back(CH_BSL);
          doc_q.push_back(8'($urandom_range(1, 255)));
        end
        6: doc_q.push_back(CH_SPACE);
        default: doc_q.push_back(8'($urandom_range(48, 57)));
      endcase
    end
  endfunction

  function automatic void add_pair();
    add_key_pattern();
    if ($urandom_range(9) == 0) begin
      // no quote after the colon
      doc_q.push_back(8'($urandom_range(97, 122)));
    end else begin
      doc_q.push_back(CH_QUOTE);
      add_value_body($urandom_range(8));
      doc_q.push_back(CH_QUOTE);
    end
  endfunction

  // Pattern with one key bit flipped, or a space in place of an empty key
  function automatic void add_near_miss();
    int j;
    doc_q.push_back(CH_QUOTE);
    j = (key_use > 0) ? $urandom_range(key_use - 1) : 0;
    for (int i = 0; i < key_use; i++)
      doc_q.push_back((i == j) ? key_copy[i] ^ (8'h01 << $urandom_range(7)) : key_copy[i]);
    if (key_use == 0) doc_q.push_back(CH_SPACE);
    doc_q.push_back(CH_QUOTE);
    doc_q.push_back(CH_COLON);
  endfunction

  function automatic void build_doc();
    int target;
    doc_q.delete();
    target = $urandom_range(4, 20);
    while (doc_q.size() < target) begin
      case ($urandom_range(5))
        0, 1, 2: add_pair();
        3: repeat ($urandom_range(1, 4)) doc_q.push_back(8'($urandom_range(1, 255)));
        4: add_near_miss();
        default: begin
          add_key_pattern();
          doc_q.push_back(CH_QUOTE);
          add_value_body($urandom_range(10, 16));
          doc_q.push_back(CH_QUOTE);
        end
      endcase
    end
    // Final byte: open value ending in backslash, open value, or any byte
    case ($urandom_range(3))
      0: begin
        add_key_pattern();
        doc_q.push_back(CH_QUOTE);
        add_value_body($urandom_range(3));
        doc_q.push_back(CH_BSL);
      end
      1: begin
        add_key_pattern();
        doc_q.push_back(CH_QUOTE);
        add_value_body($urandom_range(3));
        doc_q.push_back(8'($urandom_range(97, 122)));
      end
      default: doc_q.push_back(8'($urandom_range(1, 255)));
    endcase
  endfunction

  // ---- drivers ----

  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{doc_byte: b, doc_last: l};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_doc(input bit counted);
    for (int i = 0; i < doc_q.size(); i++) begin
      if (counted) begin
        // receiver idles first, then the sender, then neither
        if (random_sent < 110) begin
          send_idle_pct = 26;
          recv_idle_pct = 88;
        end else if (random_sent < 220) begin
          send_idle_pct = 88;
          recv_idle_pct = 26;
        end else begin
          send_idle_pct  = 0;
          recv_idle_pct  = 0;
          pressure_armed = (random_sent >= 230);
        end
        random_sent++;
      end
      send_byte(doc_q[i], i == doc_q.size() - 1);
    end
  endtask

  // Wait until the last accepted byte is noted and all its results are out
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tracker.awaited_results.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(idx, data);
  endtask

  task automatic configure(input int len, input int cap, input bit raw_key);
    logic [63:0] lo;
    logic [63:0] hi;
    for (int i = 0; i < 16; i++)
      key_copy[i] = raw_key ? 8'($urandom_range(255)) : 8'($urandom_range(97, 122));
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = key_copy[i];
      hi[8*i +: 8] = key_copy[i+8];
    end
    key_use = (len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : len;
    write_reg(REG_KEY_LOW, lo);
    write_reg(REG_KEY_HIGH, hi);
    // unused upper bits carry noise
    write_reg(REG_KEY_LEN, ({$urandom, $urandom} & ~64'h1F) | 64'(len));
    write_reg(REG_CAPACITY, ({$urandom, $urandom} & ~64'hFFFF) | 64'(cap));
    cfg_valid <= 1'b0;
  endtask

  // ---- main sequence ----

  int phase_len [9] = '{3, 16, 0, 1, 17, 31, 8, 5, -1};
  int phase_cap [9] = '{65535, 4, 0, 1, -2, 2, -2, 65535, -1};

  initial begin
    int len;
    int cap;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed document under reset registers (empty key): spaces after the
    // colon, all escapes, byte extremes, a zero byte, a non-quote after the
    // colon, and a backslash as the final byte of an open value
    doc_q.delete();
    add_text("\"\":  \"\\n\\t\\r\\q\"");
    doc_q.push_back(8'hFF);
    doc_q.push_back(8'h01);
    doc_q.push_back(8'h00);
    add_text("\"\":x\"\":\"\\");
    send_doc(1'b0);
    wait_idle();

    for (int p = 0; p < 9; p++) begin
      len = (phase_len[p] < 0) ? $urandom_range(16) : phase_len[p];
      if (phase_cap[p] == -1) cap = $urandom_range(12);
      else if (phase_cap[p] == -2) cap = $urandom_range(65535);
      else cap = phase_cap[p];
      configure(len, cap, p == 1 || p == 6);
      // at least one document per setting, about 32 counted bytes each
      do begin
        build_doc();
        send_doc(1'b1);
      end while (random_sent < 32 * (p + 1));
      wait_idle();
    end

    repeat (10) @(posedge clk);
    tracker.check_drained();
    if (tracker.errors == 0) $display("json_key_string_extractor_top_tb: PASS");
    else $display("json_key_string_extractor_top_tb: FAIL");
    $finish;
  end

  // Run limit
  initial begin
    #400000;
    $display("json_key_string_extractor_top_tb: FAIL");
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/jkse_pkg.sv
hdl/jkse_cell.sv
hdl/jkse_queue.sv
hdl/json_key_string_extractor_top.sv
hdl/jkse_checker.sv
tb/json_key_string_extractor_top_tb.sv
